// File: hdl/odet_pkg.sv
// Shared types and codes for the one-shot deadline event table.
// Used by the controller, the datapath, the top level and the checker.
// Depends on nothing.
package odet_pkg;

   // Result status codes.
   typedef enum logic [1:0] {
      ST_ACCEPTED = 2'd0,
      ST_REJECTED = 2'd1,
      ST_FIRED    = 2'd2
   } status_type;

   // Input word kinds.
   typedef enum logic {
      KIND_ADD  = 1'b0,
      KIND_TICK = 1'b1
   } kind_type;

   // Controller states.
   typedef enum logic {
      S_IDLE = 1'b0,
      S_SCAN = 1'b1
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic add_go;    // an add word is taken this cycle
      logic tick_go;   // a tick word is taken this cycle
      logic scan_run;  // scan pipeline may advance
      logic scan_fin;  // scan is complete, commit the new count
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic hold_busy; // a result still sits in the hold stage
      logic scan_done; // every entry has been read and judged
   } sts_type;

endpackage

// File: hdl/odet_ctrl.sv
// Controller for the event table: idle/scan state machine and input handshake.
// Depends on odet_pkg for the state, kind, command and status types.
module odet_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_kind,
   input  odet_pkg::sts_type   sts,
   output odet_pkg::cmd_type   cmd
);

   odet_pkg::state_type state_ff, state_in;
   logic                accept;

   // A new word is taken only when idle and the hold stage has drained.
   assign req_ready = (state_ff == odet_pkg::S_IDLE) && !sts.hold_busy;
   assign accept    = req_valid && req_ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         odet_pkg::S_IDLE: begin
            if (accept && (req_kind == odet_pkg::KIND_TICK)) state_in = odet_pkg::S_SCAN;
         end
         odet_pkg::S_SCAN: begin
            if (sts.scan_done) state_in = odet_pkg::S_IDLE;
         end
         default: state_in = odet_pkg::S_IDLE;
      endcase
   end

   // Commands to the datapath.
   always_comb begin
      cmd = '0;
      case (state_ff)
         odet_pkg::S_IDLE: begin
            cmd.add_go  = accept && (req_kind == odet_pkg::KIND_ADD);
            cmd.tick_go = accept && (req_kind == odet_pkg::KIND_TICK);
         end
         odet_pkg::S_SCAN: begin
            cmd.scan_run = !sts.scan_done;
            cmd.scan_fin = sts.scan_done;
         end
         default: cmd = '0;
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= odet_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: hdl/odet_dpath.sv
// Datapath for the event table: entry memory, scan pointers, hold stage and
// output register. Depends on odet_pkg for the status, command and code types.
module odet_dpath #(
   parameter int ENTRIES   = 16,
   parameter int TIME_BITS = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  odet_pkg::cmd_type   cmd,
   output odet_pkg::sts_type   sts,
   input  logic [7:0]          req_event_id,
   input  logic [31:0]         req_deadline,
   input  logic [31:0]         req_now_time,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_status,
   output logic [7:0]          rsp_fired_id,
   output logic                rsp_last
);

   localparam int CNT_BITS = $clog2(ENTRIES + 1);
   localparam int IDX_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   // Entry memory: deadlines and ids, one write and one registered read a cycle.
   logic [TIME_BITS-1:0] mem_dl [ENTRIES];
   logic [7:0]           mem_id [ENTRIES];

   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic [CNT_BITS-1:0]  rd_ff, rd_in;
   logic [CNT_BITS-1:0]  wr_ff, wr_in;
   logic [TIME_BITS-1:0] now_ff;
   logic [TIME_BITS-1:0] rdl_ff;
   logic [7:0]           rid_ff;
   logic                 rv_ff, rv_in;

   logic                 hold_vld_ff, hold_vld_in;
   logic                 hold_fin_ff, hold_fin_in;
   odet_pkg::status_type hold_status_ff, hold_status_in;
   logic [7:0]           hold_id_ff, hold_id_in;

   logic                 out_vld_ff, out_vld_in;
   odet_pkg::status_type out_status_ff;
   logic [7:0]           out_id_ff;
   logic                 out_last_ff;

   logic                 out_free;
   logic                 due;
   logic                 stall;
   logic                 advance;
   logic                 issue;
   logic                 push;
   logic                 move;
   logic                 full;
   logic                 mem_we;
   logic [IDX_BITS-1:0]  mem_wa;
   logic [TIME_BITS-1:0] mem_wdl;
   logic [7:0]           mem_wid;

   assign out_free = !out_vld_ff || rsp_ready;
   assign due      = (rdl_ff <= now_ff);
   assign full     = (count_ff == CNT_BITS'(ENTRIES));

   // The judge stage waits when a due entry needs the hold stage but the
   // held result has nowhere to go.
   assign stall   = rv_ff && due && hold_vld_ff && !out_free;
   assign advance = cmd.scan_run && !stall;
   assign issue   = advance && (rd_ff < count_ff);
   assign push    = advance && rv_ff && due;

   // The hold stage passes to the output register when a newer fired result
   // replaces it, or once it is known to be the final one.
   assign move = hold_vld_ff && out_free && (push || hold_fin_ff);

   assign sts.hold_busy = hold_vld_ff;
   assign sts.scan_done = (rd_ff == count_ff) && !rv_ff;

   // Memory write port: appended entry on an add, compaction during a scan.
   always_comb begin
      mem_we  = 1'b0;
      mem_wa  = count_ff[IDX_BITS-1:0];
      mem_wdl = TIME_BITS'(req_deadline);
      mem_wid = req_event_id;
      if (cmd.add_go && !full) begin
         mem_we = 1'b1;
      end else if (advance && rv_ff && !due) begin
         mem_we  = 1'b1;
         mem_wa  = wr_ff[IDX_BITS-1:0];
         mem_wdl = rdl_ff;
         mem_wid = rid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_dl[mem_wa] <= mem_wdl;
         mem_id[mem_wa] <= mem_wid;
      end
   end

   // Registered read of the entry under the read pointer.
   always_ff @(posedge clock) begin
      if (issue) begin
         rdl_ff <= mem_dl[rd_ff[IDX_BITS-1:0]];
         rid_ff <= mem_id[rd_ff[IDX_BITS-1:0]];
      end
   end

   // Count and scan pointers.
   always_comb begin
      count_in = count_ff;
      rd_in    = rd_ff;
      wr_in    = wr_ff;
      rv_in    = rv_ff;
      if (cmd.add_go && !full) begin
         count_in = count_ff + CNT_BITS'(1);
      end
      if (cmd.tick_go) begin
         rd_in = '0;
         wr_in = '0;
         rv_in = 1'b0;
      end
      if (advance) begin
         rv_in = issue;
         if (issue) rd_in = rd_ff + CNT_BITS'(1);
         if (rv_ff && !due) wr_in = wr_ff + CNT_BITS'(1);
      end
      if (cmd.scan_fin) begin
         count_in = wr_ff;
      end
   end

   // Hold stage: one result kept back until its last flag is known.
   always_comb begin
      hold_vld_in    = hold_vld_ff;
      hold_fin_in    = hold_fin_ff;
      hold_status_in = hold_status_ff;
      hold_id_in     = hold_id_ff;
      if (move) hold_vld_in = 1'b0;
      if (cmd.add_go) begin
         hold_vld_in    = 1'b1;
         hold_fin_in    = 1'b1;
         hold_status_in = full ? odet_pkg::ST_REJECTED : odet_pkg::ST_ACCEPTED;
         hold_id_in     = req_event_id;
      end else if (push) begin
         hold_vld_in    = 1'b1;
         hold_fin_in    = 1'b0;
         hold_status_in = odet_pkg::ST_FIRED;
         hold_id_in     = rid_ff;
      end else if (cmd.scan_fin) begin
         hold_fin_in = 1'b1;
      end
   end

   // Output register valid.
   always_comb begin
      out_vld_in = out_vld_ff;
      if (move) begin
         out_vld_in = 1'b1;
      end else if (rsp_ready) begin
         out_vld_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         rd_ff       <= '0;
         wr_ff       <= '0;
         rv_ff       <= 1'b0;
         hold_vld_ff <= 1'b0;
         hold_fin_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         count_ff    <= count_in;
         rd_ff       <= rd_in;
         wr_ff       <= wr_in;
         rv_ff       <= rv_in;
         hold_vld_ff <= hold_vld_in;
         hold_fin_ff <= hold_fin_in;
         out_vld_ff  <= out_vld_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      hold_status_ff <= hold_status_in;
      hold_id_ff     <= hold_id_in;
      if (cmd.tick_go) now_ff <= TIME_BITS'(req_now_time);
      if (move) begin
         out_status_ff <= hold_status_ff;
         out_id_ff     <= hold_id_ff;
         out_last_ff   <= hold_fin_ff;
      end
   end

   assign rsp_valid    = out_vld_ff;
   assign rsp_status   = out_status_ff;
   assign rsp_fired_id = out_id_ff;
   assign rsp_last     = out_last_ff;

endmodule

// File: hdl/one_shot_deadline_event_table.sv
// Top level of the one-shot deadline event table: controller plus datapath.
// Depends on odet_pkg, odet_ctrl and odet_dpath.
//
//   channel  direction  ports                                         word
//   req      in         req_valid/ready, kind, event_id, deadline,   add or tick
//                       now_time
//   rsp      out        rsp_valid/ready, status, fired_id, last      ack or fired
//
// An add's acknowledgement word passes the hold stage into the output register
// before the next input word is taken. A tick reads the stored entries one per
// cycle while the scan is not stalled, judges the last entry, commits the count
// and returns to idle; when any event fires, the final word leaves the hold
// stage before the next input word is taken.
// A fired word that cannot leave stalls the scan until rsp_ready frees the
// output register; the next input word is taken once the hold stage drains.
// Synchronous active-high reset empties the table.
module one_shot_deadline_event_table #(
   parameter int ENTRIES   = 16,
   parameter int TIME_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic [7:0]  req_event_id,
   input  logic [31:0] req_deadline,
   input  logic [31:0] req_now_time,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_fired_id,
   output logic        rsp_last
);

   odet_pkg::cmd_type cmd;
   odet_pkg::sts_type sts;

   // Sequencing of adds and ticks.
   odet_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_kind  (req_kind),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Entry storage, scan and result path.
   odet_dpath #(
      .ENTRIES   (ENTRIES),
      .TIME_BITS (TIME_BITS)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .req_event_id (req_event_id),
      .req_deadline (req_deadline),
      .req_now_time (req_now_time),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_status   (rsp_status),
      .rsp_fired_id (rsp_fired_id),
      .rsp_last     (rsp_last)
   );

endmodule

// File: hdl/odet_checker.sv
// Port-level checks for the one-shot deadline event table, bound to the top.
// Depends on odet_pkg for the status codes.
module odet_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_status,
   input logic [7:0] rsp_fired_id,
   input logic       rsp_last
);

   // A stalled result word holds still.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_fired_id) && $stable(rsp_last))
      else $error("result word changed while stalled");

   // Only the three defined status codes ever appear.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == odet_pkg::ST_ACCEPTED)
         || (rsp_status == odet_pkg::ST_REJECTED) || (rsp_status == odet_pkg::ST_FIRED))
      else $error("undefined result status");

   // An add acknowledgement is always the only, and so the final, word.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_status == odet_pkg::ST_ACCEPTED)
         || (rsp_status == odet_pkg::ST_REJECTED)) |-> rsp_last)
      else $error("add acknowledgement without last");

   // Words are handled one at a time: no input is taken in the cycle after one.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken on consecutive cycles");

endmodule

bind one_shot_deadline_event_table odet_checker u_odet_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_status   (rsp_status),
   .rsp_fired_id (rsp_fired_id),
   .rsp_last     (rsp_last)
);

// File: verif/odet_tb_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the one-shot deadline event table: a mirror of the table
// that predicts every result word, and the checker that compares them.
// Depends on odet_pkg.
package odet_tb_pkg;

   localparam int TABLE_ENTRIES = 16;
   localparam int REPORT_LIMIT  = 10;

   // One predicted result word.
   typedef struct {
      odet_pkg::status_type status;
      logic [7:0]           event_id;
      logic                 last;
   } table_result_type;

   class deadline_table_scoreboard;
      logic [31:0]      mirror_deadline [TABLE_ENTRIES];
      logic [7:0]       mirror_id [TABLE_ENTRIES];
      int unsigned      live_count;
      table_result_type awaited_results [$];
      int unsigned      failure_count;
      int unsigned      adds_accepted;
      int unsigned      adds_rejected;
      int unsigned      ticks_seen;
      int unsigned      events_fired;

      function new();
         live_count    = 0;
         failure_count = 0;
         adds_accepted = 0;
         adds_rejected = 0;
         ticks_seen    = 0;
         events_fired  = 0;
      endfunction

      // Only the first few failures are printed; the rest are just counted.
      function void report_failure(string msg);
         failure_count++;
         if (failure_count <= REPORT_LIMIT) begin
            $display("ERROR: %s", msg);
         end
      endfunction

      function void push_result(odet_pkg::status_type status, logic [7:0] event_id,
                                logic last);
         table_result_type res;
         res.status   = status;
         res.event_id = event_id;
         res.last     = last;
         awaited_results.push_back(res);
      endfunction

      // Update the mirror with an accepted input word and queue its results.
      function void note_request(odet_pkg::kind_type kind, logic [7:0] event_id,
                                 logic [31:0] deadline, logic [31:0] now_time);
         int unsigned slot;
         int unsigned keep;
         int unsigned fired;
         if (kind == odet_pkg::KIND_ADD) begin
            if (live_count >= TABLE_ENTRIES) begin
               // A full table drops the add and says so.
               adds_rejected++;
               push_result(odet_pkg::ST_REJECTED, event_id, 1'b1);
            end else begin
               mirror_deadline[live_count] = deadline;
               mirror_id[live_count]       = event_id;
               live_count++;
               adds_accepted++;
               push_result(odet_pkg::ST_ACCEPTED, event_id, 1'b1);
            end
         end else begin
            // Scan in insertion order; due entries fire, the rest close up.
            ticks_seen++;
            keep  = 0;
            fired = 0;
            for (slot = 0; slot < live_count; slot++) begin
               if (mirror_deadline[slot] <= now_time) begin
                  push_result(odet_pkg::ST_FIRED, mirror_id[slot], 1'b0);
                  fired++;
               end else begin
                  mirror_deadline[keep] = mirror_deadline[slot];
                  mirror_id[keep]       = mirror_id[slot];
                  keep++;
               end
            end
            live_count = keep;
            events_fired += fired;
            if (fired != 0) begin
               awaited_results[awaited_results.size() - 1].last = 1'b1;
            end
         end
      endfunction

      // Compare an accepted result word with the oldest prediction.
      function void check_response(logic [1:0] status, logic [7:0] fired_id, logic last);
         table_result_type want;
         if (awaited_results.size() == 0) begin
            report_failure($sformatf("unexpected result word: status %0d id %0d last %0d",
                                     status, fired_id, last));
         end else begin
            want = awaited_results.pop_front();
            if (status !== want.status || fired_id !== want.event_id ||
                last !== want.last) begin
               report_failure($sformatf(
                  "expected status %0d id %0d last %0d, got status %0d id %0d last %0d",
                  want.status, want.event_id, want.last, status, fired_id, last));
            end
         end
      endfunction
   endclass

endpackage

// File: verif/tb_one_shot_deadline_event_table.sv
`timescale 1ns / 100ps
// Testbench for one_shot_deadline_event_table: directed and random add and tick
// words with random stalls on both channels, checked by the scoreboard.
// Depends on odet_pkg, odet_tb_pkg and the block's RTL.
module tb_one_shot_deadline_event_table;

   localparam int CYCLE_LIMIT = 400000;
   localparam int TAIL_CYCLES = 40;
   localparam int PHASE_ITEMS = 52;

   logic        clock;
   logic        reset        = 1'b1;
   logic        req_valid    = 1'b0;
   logic        req_kind     = 1'b0;
   logic [7:0]  req_event_id = 8'd0;
   logic [31:0] req_deadline = 32'd0;
   logic [31:0] req_now_time = 32'd0;
   logic        rsp_ready    = 1'b0;
   logic        req_ready;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [7:0]  rsp_fired_id;
   logic        rsp_last;

   odet_tb_pkg::deadline_table_scoreboard table_sb = new();

   int          send_idle_pct = 24;
   int          recv_idle_pct = 77;
   int unsigned items_sent    = 0;
   int unsigned cycle_count   = 0;
   logic [31:0] time_base;

   one_shot_deadline_event_table u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_kind     (req_kind),
      .req_event_id (req_event_id),
      .req_deadline (req_deadline),
      .req_now_time (req_now_time),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_status   (rsp_status),
      .rsp_fired_id (rsp_fired_id),
      .rsp_last     (rsp_last)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The receiver stalls at random according to the current phase.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Every result word taken is checked against the prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         table_sb.check_response(rsp_status, rsp_fired_id, rsp_last);
      end
   end

   // Guard against a hung block.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_one_shot_deadline_event_table failed");
         $finish;
      end
   end

   // Offer one word, idling first at random, and wait until it is taken.
   task automatic send_word(odet_pkg::kind_type kind, logic [7:0] event_id,
                            logic [31:0] deadline, logic [31:0] now_time);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid    <= 1'b1;
      req_kind     <= kind;
      req_event_id <= event_id;
      req_deadline <= deadline;
      req_now_time <= now_time;
      do @(posedge clock); while (!req_ready);
      table_sb.note_request(kind, event_id, deadline, now_time);
      items_sent++;
   endtask

   // Hold the sender back until every predicted word has arrived.
   task automatic hold_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (table_sb.awaited_results.size() != 0);
   endtask

   // Adds mostly fall a little ahead of the running time, sometimes on it.
   task automatic send_random_add();
      logic [31:0] deadline;
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 8) begin
         deadline = $urandom;
      end else if (pick < 16) begin
         deadline = time_base;
      end else begin
         deadline = time_base + $urandom_range(1, 400);
      end
      send_word(odet_pkg::KIND_ADD, 8'($urandom_range(255)), deadline, $urandom);
   endtask

   // Ticks mostly move time forward; a few jump anywhere or step back.
   task automatic send_random_tick();
      logic [31:0] now_time;
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 8) begin
         now_time = $urandom;
      end else if (pick < 14) begin
         now_time = time_base - $urandom_range(0, 100);
      end else begin
         time_base = time_base + $urandom_range(0, 120);
         now_time  = time_base;
      end
      send_word(odet_pkg::KIND_TICK, 8'($urandom_range(255)), $urandom, now_time);
   endtask

   // One phase of random traffic under the given idle rates.
   task automatic run_phase(int send_pct, int recv_pct);
      int unsigned target;
      int unsigned pick;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
         pick = $urandom_range(99);
         if (pick < 4) begin
            // Fill the table and push two more adds past the top.
            while (table_sb.live_count < odet_tb_pkg::TABLE_ENTRIES) send_random_add();
            send_random_add();
            send_random_add();
         end else if (pick < 7) begin
            hold_until_drained();
         end else if (pick < 55) begin
            send_random_add();
         end else begin
            send_random_tick();
         end
      end
      hold_until_drained();
   endtask

   initial begin
      int unsigned slot;
      logic [31:0] preset_deadline;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      time_base = $urandom_range(0, 32'h0fff_ffff);

      // Directed part: fill the table with extreme ids and deadlines.
      for (slot = 0; slot < odet_tb_pkg::TABLE_ENTRIES; slot++) begin
         case (slot)
            0: preset_deadline = 32'd0;
            1: preset_deadline = 32'hffff_ffff;
            2, 3: preset_deadline = 32'd1000;
            4: preset_deadline = 32'd999;
            5: preset_deadline = 32'd1001;
            default: preset_deadline = 32'd5000 + slot * 10;
         endcase
         send_word(odet_pkg::KIND_ADD, 8'(slot * 17), preset_deadline, $urandom);
      end
      // An add to a full table is turned away.
      send_word(odet_pkg::KIND_ADD, 8'ha5, 32'd0, $urandom);
      // A deadline equal to the time fires; a repeat of that time finds nothing.
      send_word(odet_pkg::KIND_TICK, 8'($urandom_range(255)), $urandom, 32'd0);
      send_word(odet_pkg::KIND_TICK, 8'($urandom_range(255)), $urandom, 32'd0);
      // Several due entries from the middle fire in insertion order.
      send_word(odet_pkg::KIND_TICK, 8'($urandom_range(255)), $urandom, 32'd1000);
      send_word(odet_pkg::KIND_ADD, 8'h5a, 32'd1000, 32'hffff_ffff);
      // The largest time empties the table; a tick on an empty table is silent.
      send_word(odet_pkg::KIND_TICK, 8'($urandom_range(255)), $urandom, 32'hffff_ffff);
      send_word(odet_pkg::KIND_TICK, 8'($urandom_range(255)), $urandom, 32'hffff_ffff);
      hold_until_drained();

      // Random part in three idling phases.
      run_phase(24, 77);
      run_phase(77, 24);
      run_phase(0, 0);

      // Let any stray word show up before the verdict.
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Covered %0d accepted and %0d rejected adds, %0d ticks, %0d fired events.",
               table_sb.adds_accepted, table_sb.adds_rejected, table_sb.ticks_seen,
               table_sb.events_fired);
      $display("%0d result words were wrong or unexpected.", table_sb.failure_count);
      if (table_sb.failure_count == 0) begin
         $display("tb_one_shot_deadline_event_table passed");
      end else begin
         $display("tb_one_shot_deadline_event_table failed");
      end
      $finish;
   end

endmodule
